[sv/zcwa_pkg.sv]
// ----------------------------------------------------------------------------
// zcwa_pkg - shared definitions for the zero crossing wave analyser
// Field widths, register indexes, mode and direction codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package zcwa_pkg;

  // field widths
  localparam int SAMPLE_BITS = 24;
  localparam int TIME_BITS   = 32;
  localparam int PERIOD_BITS = 24;
  localparam int MODE_BITS   = 2;

  // configuration channel
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = PERIOD_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CROSSING_MODE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = CFG_INDEX_BITS'(1);

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(256);

  // crossing mode codes
  localparam logic [MODE_BITS-1:0] MODE_UP   = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_DOWN = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_BOTH = MODE_BITS'(2);

  // wave direction codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // sample extremes
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // interpolation divider sizes
  localparam int NUM_BITS  = SAMPLE_BITS;
  localparam int DEN_BITS  = SAMPLE_BITS + 1;
  localparam int PROD_BITS = SAMPLE_BITS + PERIOD_BITS;
  localparam int STEP_BITS = $clog2(PERIOD_BITS);

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic restart;
    logic fold_prior;
    logic store_prior;
    logic mult_load;
    logic div_init;
    logic div_step;
    logic close;
  } zcwa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_fire;
    logic first;
    logic crossing;
    logic out_busy;
  } zcwa_sts_t;

endpackage

[sv/zcwa_if.sv]
// ----------------------------------------------------------------------------
// zcwa_if - channel interfaces of the zero crossing wave analyser
// Sample input, wave result and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface zcwa_sample_if import zcwa_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] elevation;
  logic        [TIME_BITS-1:0]   sample_time;
  logic                          record_start;

  modport source (output valid, elevation, sample_time, record_start, input ready);
  modport sink   (input valid, elevation, sample_time, record_start, output ready);
endinterface

interface zcwa_wave_if import zcwa_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          wave_direction;
  logic        [TIME_BITS-1:0]   wave_start;
  logic        [TIME_BITS-1:0]   wave_duration;
  logic signed [SAMPLE_BITS-1:0] wave_max;
  logic signed [SAMPLE_BITS-1:0] wave_min;

  modport source (output valid, wave_direction, wave_start, wave_duration, wave_max,
                  wave_min, input ready);
  modport sink   (input valid, wave_direction, wave_start, wave_duration, wave_max,
                  wave_min, output ready);
endinterface

interface zcwa_cfg_if import zcwa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/zcwa_ctrl.sv]
// ----------------------------------------------------------------------------
// zcwa_ctrl - sequencer of the zero crossing wave analyser
// Accepts one sample, classifies it, runs the interpolation divider on a
// crossing and closes the wave once the result register is free.
// ----------------------------------------------------------------------------
module zcwa_ctrl import zcwa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  zcwa_sts_t sts,
  output zcwa_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_CLOSE  = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step;

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // count divider steps
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_PREP) begin
      step <= '0;
    end else if (state == ST_DIVIDE) begin
      step <= step + STEP_BITS'(1);
    end
  end

  // decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.first) begin
          cmd.restart     = 1'b1;
          cmd.store_prior = 1'b1;
          state_next      = ST_IDLE;
        end else if (!sts.crossing) begin
          cmd.fold_prior  = 1'b1;
          cmd.store_prior = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.fold_prior = 1'b1;
          cmd.mult_load  = 1'b1;
          state_next     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (step == STEP_BITS'(PERIOD_BITS - 1)) begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        // hold until the result register can take a new transaction
        if (!sts.out_busy) begin
          cmd.close       = 1'b1;
          cmd.store_prior = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/zcwa_datapath.sv]
// ----------------------------------------------------------------------------
// zcwa_datapath - storage and arithmetic of the zero crossing wave analyser
// Holds configuration, the prior sample, both wave trackers, the
// interpolation multiplier and restoring divider, and the result register.
// ----------------------------------------------------------------------------
module zcwa_datapath import zcwa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  zcwa_sample_if.sink  sample,
  zcwa_wave_if.source  wave,
  zcwa_cfg_if.sink     cfg,
  input  zcwa_cmd_t    cmd,
  output zcwa_sts_t    sts
);

  // configuration
  logic [MODE_BITS-1:0]   crossing_mode;
  logic [PERIOD_BITS-1:0] sample_period;

  // captured sample
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic        [TIME_BITS-1:0]   cur_time;
  logic                          cur_start;

  // prior sample
  logic signed [SAMPLE_BITS-1:0] prior_sample;
  logic        [TIME_BITS-1:0]   prior_time;
  logic                          prior_valid;

  // trackers
  logic                          up_started;
  logic        [TIME_BITS-1:0]   up_begin_time;
  logic signed [SAMPLE_BITS-1:0] up_peak;
  logic signed [SAMPLE_BITS-1:0] up_trough;
  logic                          down_started;
  logic        [TIME_BITS-1:0]   down_begin_time;
  logic signed [SAMPLE_BITS-1:0] down_peak;
  logic signed [SAMPLE_BITS-1:0] down_trough;

  // interpolation
  logic signed [DEN_BITS-1:0]  prior_ext;
  logic signed [DEN_BITS-1:0]  cur_ext;
  logic signed [DEN_BITS-1:0]  num_full;
  logic        [NUM_BITS-1:0]  num;
  logic        [DEN_BITS-1:0]  den_calc;
  logic        [PROD_BITS-1:0] product;
  logic        [DEN_BITS-1:0]  den;
  logic        [DEN_BITS-1:0]  rem;
  logic        [PERIOD_BITS-1:0] quot;
  logic        [DEN_BITS:0]    trial;
  logic        [DEN_BITS:0]    diff;
  logic                        prior_nonneg;
  logic        [TIME_BITS-1:0] cross_time;

  // result register
  logic out_valid;
  logic in_fire;
  logic out_fire;

  assign in_fire  = sample.valid && cmd.in_ready;
  assign out_fire = out_valid && wave.ready;
  assign sample.ready = cmd.in_ready;
  assign cfg.ready    = 1'b1;
  assign wave.valid   = out_valid;

  // status toward the controller
  assign prior_nonneg = !prior_sample[SAMPLE_BITS-1];
  assign sts.in_fire  = in_fire;
  assign sts.first    = cur_start || !prior_valid;
  assign sts.crossing = prior_nonneg != !cur_sample[SAMPLE_BITS-1];
  assign sts.out_busy = out_valid && !wave.ready;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_mode <= MODE_UP;
      sample_period <= PERIOD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CROSSING_MODE: crossing_mode <= cfg.data[MODE_BITS-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg.data[PERIOD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // capture the accepted sample
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_sample <= sample.elevation;
      cur_time   <= sample.sample_time;
      cur_start  <= sample.record_start;
    end
  end

  // keep the prior sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_sample <= '0;
      prior_time   <= '0;
      prior_valid  <= 1'b0;
    end else if (cmd.store_prior) begin
      prior_sample <= cur_sample;
      prior_time   <= cur_time;
      prior_valid  <= 1'b1;
    end
  end

  // numerator and denominator of the crossing offset
  assign prior_ext = {prior_sample[SAMPLE_BITS-1], prior_sample};
  assign cur_ext   = {cur_sample[SAMPLE_BITS-1], cur_sample};
  assign num_full  = prior_nonneg ? prior_ext : -prior_ext;
  assign num       = num_full[NUM_BITS-1:0];
  assign den_calc  = prior_nonneg ? DEN_BITS'(prior_ext - cur_ext)
                                  : DEN_BITS'(cur_ext - prior_ext);

  // multiply, then divide one quotient bit a cycle
  assign trial = {rem, quot[PERIOD_BITS-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.mult_load) begin
      product <= PROD_BITS'(num) * PROD_BITS'(sample_period);
      den     <= den_calc;
    end
    if (cmd.div_init) begin
      // quotient fits the period width, so the upper half is already below den
      rem  <= DEN_BITS'(product[PROD_BITS-1:PERIOD_BITS]);
      quot <= product[PERIOD_BITS-1:0];
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, den}) begin
        rem  <= diff[DEN_BITS-1:0];
        quot <= {quot[PERIOD_BITS-2:0], 1'b1};
      end else begin
        rem  <= trial[DEN_BITS-1:0];
        quot <= {quot[PERIOD_BITS-2:0], 1'b0};
      end
    end
  end

  assign cross_time = prior_time + TIME_BITS'({{TIME_BITS{1'b0}}, quot});

  // update trackers: restart, fold in the prior sample, or close a wave
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      up_started      <= 1'b0;
      up_begin_time   <= '0;
      up_peak         <= SAMPLE_MIN;
      up_trough       <= SAMPLE_MAX;
      down_started    <= 1'b0;
      down_begin_time <= '0;
      down_peak       <= SAMPLE_MIN;
      down_trough     <= SAMPLE_MAX;
    end else if (cmd.fold_prior) begin
      if (prior_sample > up_peak)     up_peak     <= prior_sample;
      if (prior_sample < up_trough)   up_trough   <= prior_sample;
      if (prior_sample > down_peak)   down_peak   <= prior_sample;
      if (prior_sample < down_trough) down_trough <= prior_sample;
    end else if (cmd.close) begin
      if (prior_nonneg) begin
        down_started    <= 1'b1;
        down_begin_time <= cross_time;
        down_peak       <= SAMPLE_MIN;
        down_trough     <= SAMPLE_MAX;
      end else begin
        up_started      <= 1'b1;
        up_begin_time   <= cross_time;
        up_peak         <= SAMPLE_MIN;
        up_trough       <= SAMPLE_MAX;
      end
    end
  end

  // result register: drop on a taken transaction, load on a reported wave
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (cmd.close) begin
        if (prior_nonneg && down_started && crossing_mode != MODE_UP) begin
          out_valid <= 1'b1;
        end else if (!prior_nonneg && up_started && crossing_mode != MODE_DOWN) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      if (prior_nonneg) begin
        if (down_started && crossing_mode != MODE_UP) begin
          wave.wave_direction <= DIR_DOWN;
          wave.wave_start     <= down_begin_time;
          wave.wave_duration  <= cross_time - down_begin_time;
          wave.wave_max       <= down_peak;
          wave.wave_min       <= down_trough;
        end
      end else begin
        if (up_started && crossing_mode != MODE_DOWN) begin
          wave.wave_direction <= DIR_UP;
          wave.wave_start     <= up_begin_time;
          wave.wave_duration  <= cross_time - up_begin_time;
          wave.wave_max       <= up_peak;
          wave.wave_min       <= up_trough;
        end
      end
    end
  end

endmodule

[sv/zero_crossing_wave_analyser.sv]
// ----------------------------------------------------------------------------
// zero_crossing_wave_analyser - zero crossing wave analysis for one probe
// Finds up and down crossings in an elevation stream, interpolates the
// crossing times and reports start, duration, maximum and minimum per wave.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  sample   in   valid/ready    elevation, sample_time, record_start
//  wave     out  valid/ready    wave_direction, wave_start, wave_duration,
//                               wave_max, wave_min
//  cfg      in   valid/ready    index, data (0 crossing_mode, 1 sample_period)
//
//  A sample with no crossing passes the idle and evaluate states; a crossing
//  adds prepare, restoring divide at one quotient bit a cycle, and close.
//  Reset (rst, synchronous) clears the trackers and loads mode 0, period 256.
//  The result register frees the input side; a crossing only waits in its
//  closing cycle while an earlier transaction is still not taken.
//  cfg is always ready.
// ----------------------------------------------------------------------------
module zero_crossing_wave_analyser import zcwa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  zcwa_sample_if.sink sample,
  zcwa_wave_if.source wave,
  zcwa_cfg_if.sink    cfg
);

  zcwa_cmd_t cmd;
  zcwa_sts_t sts;

  zcwa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  zcwa_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .wave   (wave),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts)
  );

  // a wave is never closed over a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.close |-> !(wave.valid && !wave.ready))
    else $error("wave closed while result register busy");

  // one sample at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample accepted while previous one in progress");

  // the divider only starts on a real crossing
  a_mult_on_crossing: assert property (@(posedge clk) disable iff (rst)
    cmd.mult_load |-> (sts.crossing && !sts.first))
    else $error("interpolation started without a crossing");

endmodule

[bench/zcwa_wave_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zcwa_wave_checker - wave result checker for the zero crossing analyser
// Watches the sample, wave and cfg channels, runs its own copy of the
// crossing trackers on every sample transaction and compares each wave
// transaction, field by field, with the oldest predicted wave.
// ----------------------------------------------------------------------------
module zcwa_wave_checker import zcwa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  zcwa_sample_if sample_ch,
  zcwa_wave_if   wave_ch,
  zcwa_cfg_if    cfg_ch,
  output int     errors,
  output int     waves_pending
);

  typedef struct packed {
    logic                          direction;
    logic        [TIME_BITS-1:0]   open_time;
    logic        [TIME_BITS-1:0]   span;
    logic signed [SAMPLE_BITS-1:0] peak;
    logic signed [SAMPLE_BITS-1:0] trough;
  } wave_rec_t;

  wave_rec_t expected_waves[$];
  int        error_count = 0;

  // register copies
  logic [MODE_BITS-1:0]   mode;
  logic [PERIOD_BITS-1:0] period;

  // previous sample of the record
  logic signed [SAMPLE_BITS-1:0] prior_elev;
  logic        [TIME_BITS-1:0]   prior_stamp;
  logic                          prior_ok;

  // one tracker per direction, indexed by DIR_UP / DIR_DOWN
  logic                          started   [2];
  logic        [TIME_BITS-1:0]   open_time [2];
  logic signed [SAMPLE_BITS-1:0] peak      [2];
  logic signed [SAMPLE_BITS-1:0] trough    [2];

  assign errors = error_count;

  task automatic restart_trackers();
    for (int d = 0; d < 2; d++) begin
      started[d]   = 1'b0;
      open_time[d] = '0;
      peak[d]      = SAMPLE_MIN;
      trough[d]    = SAMPLE_MAX;
    end
  endtask

  // Advance the trackers by one sample and queue the wave it closes, if any.
  task automatic track_sample(input logic signed [SAMPLE_BITS-1:0] elev,
                              input logic [TIME_BITS-1:0] stamp, input logic rs);
    longint                 pv;
    longint                 nv;
    longint                 num;
    longint                 den;
    longint                 offset;
    logic [TIME_BITS-1:0]   cross_time;
    logic                   dir;
    logic                   report;
    wave_rec_t              w;
    if (rs || !prior_ok) begin
      restart_trackers();
    end else begin
      // the previous sample belongs to whatever wave is open
      for (int d = 0; d < 2; d++) begin
        if (prior_elev > peak[d]) peak[d] = prior_elev;
        if (prior_elev < trough[d]) trough[d] = prior_elev;
      end
      if (prior_elev[SAMPLE_BITS-1] != elev[SAMPLE_BITS-1]) begin
        pv     = prior_elev;
        nv     = elev;
        num    = (pv < 0) ? -pv : pv;
        den    = (pv < 0) ? nv - pv : pv - nv;
        offset = (num * longint'(period)) / den;
        cross_time = prior_stamp + TIME_BITS'(offset);
        // non-negative to negative closes a down wave, else an up wave
        dir    = (pv < 0) ? DIR_UP : DIR_DOWN;
        report = (dir == DIR_UP) ? (mode != MODE_DOWN) : (mode != MODE_UP);
        if (started[dir] && report) begin
          w.direction = dir;
          w.open_time = open_time[dir];
          w.span      = cross_time - open_time[dir];
          w.peak      = peak[dir];
          w.trough    = trough[dir];
          expected_waves.push_back(w);
        end
        started[dir]   = 1'b1;
        open_time[dir] = cross_time;
        peak[dir]      = SAMPLE_MIN;
        trough[dir]    = SAMPLE_MAX;
      end
    end
    prior_elev  = elev;
    prior_stamp = stamp;
    prior_ok    = 1'b1;
  endtask

  always @(posedge clk) begin
    wave_rec_t want;
    if (rst) begin
      mode        = MODE_UP;
      period      = PERIOD_RESET;
      prior_elev  = '0;
      prior_stamp = '0;
      prior_ok    = 1'b0;
      restart_trackers();
      expected_waves.delete();
    end else begin
      // register write transaction
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_CROSSING_MODE) mode = cfg_ch.data[MODE_BITS-1:0];
        else if (cfg_ch.index == REG_SAMPLE_PERIOD) period = cfg_ch.data[PERIOD_BITS-1:0];
      end
      // compare a wave transaction before predicting from a new sample
      if (wave_ch.valid && wave_ch.ready) begin
        if (expected_waves.size() == 0) begin
          $error("unexpected wave: direction %0d start %0h duration %0h",
                 wave_ch.wave_direction, wave_ch.wave_start, wave_ch.wave_duration);
          error_count++;
        end else begin
          want = expected_waves.pop_front();
          if (wave_ch.wave_direction !== want.direction) begin
            $error("wave_direction: expected %0d, got %0d",
                   want.direction, wave_ch.wave_direction);
            error_count++;
          end
          if (wave_ch.wave_start !== want.open_time) begin
            $error("wave_start: expected %0h, got %0h", want.open_time, wave_ch.wave_start);
            error_count++;
          end
          if (wave_ch.wave_duration !== want.span) begin
            $error("wave_duration: expected %0h, got %0h", want.span, wave_ch.wave_duration);
            error_count++;
          end
          if (wave_ch.wave_max !== want.peak) begin
            $error("wave_max: expected %0d, got %0d", want.peak, wave_ch.wave_max);
            error_count++;
          end
          if (wave_ch.wave_min !== want.trough) begin
            $error("wave_min: expected %0d, got %0d", want.trough, wave_ch.wave_min);
            error_count++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        track_sample(sample_ch.elevation, sample_ch.sample_time, sample_ch.record_start);
      end
    end
    waves_pending <= expected_waves.size();
  end

endmodule

[bench/tb_zero_crossing_wave_analyser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zero_crossing_wave_analyser - testbench top for the wave analyser
// Drives directed and random elevation records through the analyser under
// several mode and period settings, with random stalls on both sides early in the run; the
// checker beside the block predicts every wave and counts mismatches.
// ----------------------------------------------------------------------------
module tb_zero_crossing_wave_analyser import zcwa_pkg::*; ();

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 40;     // longer than one crossing computation
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_DIRECTED     = 22;
  localparam int N_SETTINGS     = 7;
  localparam int ITEMS_PER_SET  = 204;

  logic clk;
  logic rst;
  int   errors;
  int   waves_pending;
  int   quiet_cycles;
  int   items_sent;
  int   tx_idle_pct;
  int   rx_idle_pct;

  // random wave shaping state
  logic [TIME_BITS-1:0] cur_time;
  logic                 neg_half;
  int                   run_left;
  int                   amp;

  zcwa_sample_if sample_ch ();
  zcwa_wave_if   wave_ch ();
  zcwa_cfg_if    cfg_ch ();

  zero_crossing_wave_analyser DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .wave   (wave_ch),
    .cfg    (cfg_ch)
  );

  zcwa_wave_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .sample_ch     (sample_ch),
    .wave_ch       (wave_ch),
    .cfg_ch        (cfg_ch),
    .errors        (errors),
    .waves_pending (waves_pending)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // random back pressure on the wave side
  always @(posedge clk) begin
    wave_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (wave_ch.valid && wave_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample, with random idle cycles first, and hold until taken.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] elev,
                             input logic [TIME_BITS-1:0] stamp, input logic rs);
    if (items_sent < 480) begin
      tx_idle_pct = 12;
      rx_idle_pct = 56;
    end else if (items_sent < 960) begin
      tx_idle_pct = 56;
      rx_idle_pct = 12;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.elevation    <= elev;
    sample_ch.sample_time  <= stamp;
    sample_ch.record_start <= rs;
    do @(posedge clk); while (!sample_ch.ready);
    items_sent++;
  endtask

  // Stop offering samples until every predicted wave is out and the block is quiet.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (waves_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write both registers, junk in the unused mode bits, and optionally an unused index.
  task automatic configure(input logic [MODE_BITS-1:0] mode, input logic [PERIOD_BITS-1:0] per,
                           input bit poke_unused);
    write_reg(REG_CROSSING_MODE,
              {(CFG_DATA_BITS - MODE_BITS)'($urandom), mode});
    write_reg(REG_SAMPLE_PERIOD, per);
    if (poke_unused) begin
      write_reg(CFG_INDEX_BITS'($urandom_range(REG_SAMPLE_PERIOD + 1, {CFG_INDEX_BITS{1'b1}})),
                CFG_DATA_BITS'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Build one random sample: mostly alternating half waves, some noise.
  task automatic send_random();
    logic signed [SAMPLE_BITS-1:0] elev;
    logic                          rs;
    rs = ($urandom_range(99) < 2);
    if ((rs && $urandom_range(1)) || $urandom_range(99) == 0) begin
      cur_time = $urandom();
    end else begin
      cur_time += TIME_BITS'($urandom_range(1, 1024));
    end
    if (run_left == 0) begin
      neg_half = !neg_half;
      run_left = $urandom_range(1, 6);
      case ($urandom_range(3))
        0:       amp = $urandom_range(0, 15);
        1:       amp = $urandom_range(0, 4095);
        2:       amp = $urandom_range(0, int'(SAMPLE_MAX));
        default: amp = int'(SAMPLE_MAX);
      endcase
    end
    run_left--;
    if ($urandom_range(99) < 10) begin
      elev = SAMPLE_BITS'($urandom);
    end else if (neg_half) begin
      elev = SAMPLE_BITS'(-$urandom_range(1, amp + 1));
    end else begin
      elev = SAMPLE_BITS'($urandom_range(0, amp));
    end
    send_sample(elev, cur_time, rs);
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] dir_elev [N_DIRECTED];
    bit                            dir_rs [N_DIRECTED];
    logic [MODE_BITS-1:0]   mode_plan [N_SETTINGS];
    logic [PERIOD_BITS-1:0] period_plan [N_SETTINGS];
    logic [TIME_BITS-1:0]   base_time;

    dir_elev = '{
      24'sd0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 24'sd0, -24'sd1, 24'sd1, 24'sd5,
      -24'sd3, -24'sd7, 24'sd2, -24'sd4, 24'sd4, -24'sd4, 24'sd4, 24'sd0,
      24'sd0, SAMPLE_MIN, SAMPLE_MAX, -24'sd1, 24'sd1, 24'sd3};
    // first item has no record start on purpose; two later ones cut records
    dir_rs = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};

    rst                    <= 1'b1;
    sample_ch.valid        <= 1'b0;
    sample_ch.elevation    <= '0;
    sample_ch.sample_time  <= '0;
    sample_ch.record_start <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= '0;
    cfg_ch.data            <= '0;
    items_sent  = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 56;
    neg_half    = 1'b0;
    run_left    = 0;
    amp         = 0;

    // mode with both bits set reports both kinds; period zero gives no offset
    mode_plan   = '{MODE_UP, MODE_DOWN, MODE_BOTH, MODE_BOTH | MODE_DOWN, MODE_BOTH,
                    MODE_UP, MODE_DOWN};
    period_plan = '{PERIOD_RESET, PERIOD_BITS'(1), {PERIOD_BITS{1'b1}}, '0,
                    PERIOD_BITS'($urandom_range(1, {PERIOD_BITS{1'b1}})),
                    PERIOD_BITS'(3), PERIOD_BITS'(100)};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero on either side, wrap of the time stamp
    configure(MODE_BOTH, PERIOD_RESET, 1'b0);
    base_time = 32'hFFFF_F800;
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(dir_elev[i], base_time + TIME_BITS'(i * 256), dir_rs[i]);
    end
    cur_time = base_time + TIME_BITS'(N_DIRECTED * 256);

    // random records under each setting; trackers carry over between settings
    for (int s = 0; s < N_SETTINGS; s++) begin
      drain();
      configure(mode_plan[s], period_plan[s], (s % 3) == 1);
      repeat (ITEMS_PER_SET) send_random();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
